// ----- rtl/core/fbfla_pkg.sv -----
// Shared widths, constants and controller-to-datapath command type for the block allocator.
package fbfla_pkg;

  localparam int BLOCKS = 256;                 // depth of the link memory
  localparam int IDX_W  = 8;                   // block index width
  localparam int CNT_W  = 9;                   // counts up to 256
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;              // 19 payload bits padded to 3 bytes

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(BLOCKS);

  typedef struct packed {
    logic load;   // capture request, launch link read
    logic exec;   // commit state update, load result register
  } cmd_t;

endpackage

// ----- rtl/core/fbfla_ctrl.sv -----
// Sequencer: takes a request, runs the link read then the update, owns the result valid.
module fbfla_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output fbfla_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- rtl/core/fbfla_dp.sv -----
// Datapath: list state, link memory, range checks and the result register.
module fbfla_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fbfla_pkg::cmd_t                  cmd,
  input  logic                             req_kind,
  input  logic [fbfla_pkg::IDX_W-1:0]      req_index,
  input  logic                             cfg_wr_en,
  input  logic [fbfla_pkg::CNT_W-1:0]      cfg_wr_data,
  output logic                             res_ok,
  output logic [fbfla_pkg::IDX_W-1:0]      res_granted,
  output logic [fbfla_pkg::CNT_W-1:0]      res_free,
  output logic                             res_in_range
);

  localparam int IW = fbfla_pkg::IDX_W;
  localparam int CW = fbfla_pkg::CNT_W;

  // link memory: next block in the free list, or block_count as end marker
  logic [CW-1:0] link_mem [fbfla_pkg::BLOCKS];
  logic [CW-1:0] rd_data_r;

  logic [CW-1:0] block_count_r;
  logic [IW-1:0] head_r, head_nxt;
  logic          head_valid_r, head_valid_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [CW-1:0] linked_r, linked_nxt;
  logic          kind_r;
  logic [IW-1:0] idx_r;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [CW-1:0] wr_data;
  logic          ok, in_range, lazy;
  logic [IW-1:0] granted;
  logic [CW-1:0] linked_inc, free_dec, cfg_count;
  logic [IW-1:0] next_head;

  assign linked_inc = linked_r + CW'(1);
  assign free_dec   = free_r - CW'(1);
  assign in_range   = ({1'b0, idx_r} < block_count_r);
  assign lazy       = (linked_r < block_count_r);

  // the lazy link written this step may be the one the pop reads
  assign next_head = (lazy && (linked_r[IW-1:0] == head_r)) ? linked_inc[IW-1:0]
                                                           : rd_data_r[IW-1:0];

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_count = CW'(1);
    end else if (cfg_wr_data > fbfla_pkg::MAX_COUNT) begin
      cfg_count = fbfla_pkg::MAX_COUNT;
    end else begin
      cfg_count = cfg_wr_data;
    end
  end

  always_comb begin
    head_nxt       = head_r;
    head_valid_nxt = head_valid_r;
    free_nxt       = free_r;
    linked_nxt     = linked_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = head_valid_r ? {1'b0, head_r} : block_count_r;
    ok             = 1'b0;
    granted        = '0;
    if (!kind_r) begin
      if (lazy) begin
        wr_en      = 1'b1;
        wr_addr    = linked_r[IW-1:0];
        wr_data    = linked_inc;
        linked_nxt = linked_inc;
      end
      if (free_r != '0) begin
        ok       = 1'b1;
        granted  = head_r;
        free_nxt = free_dec;
        if (free_dec != '0) begin
          head_nxt       = next_head;
          head_valid_nxt = 1'b1;
        end else begin
          head_nxt       = '0;
          head_valid_nxt = 1'b0;
        end
      end
    end else begin
      if (in_range && (free_r < block_count_r)) begin
        wr_en          = 1'b1;
        head_nxt       = idx_r;
        head_valid_nxt = 1'b1;
        free_nxt       = free_r + CW'(1);
        ok             = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data_r <= link_mem[head_r];
    end
    if (cmd.exec && wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= req_kind;
      idx_r  <= req_index;
    end
    if (cmd.exec) begin
      res_ok       <= ok;
      res_granted  <= granted;
      res_free     <= free_nxt;
      res_in_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= fbfla_pkg::MAX_COUNT;
      head_r        <= '0;
      head_valid_r  <= 1'b1;
      free_r        <= fbfla_pkg::MAX_COUNT;
      linked_r      <= '0;
    end else if (cfg_wr_en) begin
      block_count_r <= cfg_count;
      head_r        <= '0;
      head_valid_r  <= 1'b1;
      free_r        <= cfg_count;
      linked_r      <= '0;
    end else if (cmd.exec) begin
      head_r        <= head_nxt;
      head_valid_r  <= head_valid_nxt;
      free_r        <= free_nxt;
      linked_r      <= linked_nxt;
    end
  end

endmodule

// ----- rtl/core/fixed_block_free_list_allocator.sv -----
// Top level of the fixed-block free-list allocator: sequencer plus datapath.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tuser: kind; tdata[7:0]: block_index
//  out_     out  out_tvalid/out_tready  tdata: ok, granted_index, free_count, in_range
//  cfg_     in   cfg_wr_en              cfg_wr_data: block_count
//
// Each item runs as a load step, which reads the head block's link from the
// registered-output link memory, then an update step that updates head/count and
// writes the one link the item needs. A new item is taken the cycle after that.
// Reset (rst_n low, synchronous): pool of 256 blocks, head 0, nothing linked.
// A stalled result sits in the output register; the next item is accepted
// meanwhile and waits in its update cycle until the register frees up.
// Writing block_count restarts the list; the link memory needs no clearing.
module fixed_block_free_list_allocator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [fbfla_pkg::IN_DATA_W-1:0]       in_tdata,   // [7:0] block_index
  input  logic                                  in_tuser,   // [0] kind: 0 alloc, 1 free
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] ok, [8:1] granted_index, [17:9] free_count, [18] in_range, [23:19] zero
  output logic [fbfla_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [fbfla_pkg::CNT_W-1:0]           cfg_wr_data  // block_count
);

  fbfla_pkg::cmd_t                 cmd;
  logic                            res_ok;
  logic [fbfla_pkg::IDX_W-1:0]     res_granted;
  logic [fbfla_pkg::CNT_W-1:0]     res_free;
  logic                            res_in_range;

  fbfla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  fbfla_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .req_kind     (in_tuser),
    .req_index    (in_tdata[fbfla_pkg::IDX_W-1:0]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .res_ok       (res_ok),
    .res_granted  (res_granted),
    .res_free     (res_free),
    .res_in_range (res_in_range)
  );

  assign out_tdata = {5'b0, res_in_range, res_free, res_granted, res_ok};

endmodule

// ----- rtl/core/fbfla_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
module fbfla_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [fbfla_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // one item in flight: no accept on the cycle after an accept
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted during update cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[17:9] <= fbfla_pkg::MAX_COUNT))
    else $error("free count above pool size");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[8:1] == '0))
    else $error("granted index set on rejected item");

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_fbfla_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/sv/fixed_block_free_list_allocator_tb.sv -----
// Self-checking testbench for the fixed-block free-list allocator.
module fixed_block_free_list_allocator_tb;

  // Request kinds as carried on in_tuser.
  typedef enum logic {REQ_ALLOC = 1'b0, REQ_FREE = 1'b1} req_kind_t;

  // Result layout from bit 0 up: ok, granted_index, free_count, in_range.
  typedef struct packed {
    logic                        in_rng;
    logic [fbfla_pkg::CNT_W-1:0] free_n;
    logic [fbfla_pkg::IDX_W-1:0] granted;
    logic                        ok;
  } result_t;

  localparam int CYCLE_LIMIT = 500000;

  // Tracks the pool state, predicts one result per accepted request and
  // checks the results in order.
  class free_list_predictor;
    logic [fbfla_pkg::CNT_W-1:0] link_mem [fbfla_pkg::BLOCKS];
    logic [fbfla_pkg::IDX_W-1:0] head_blk;
    logic                        head_live;
    logic [fbfla_pkg::CNT_W-1:0] free_n;
    logic [fbfla_pkg::CNT_W-1:0] linked_n;
    logic [fbfla_pkg::CNT_W-1:0] pool_n;
    result_t                     outcome_q [$];
    logic [fbfla_pkg::IDX_W-1:0] held_q [$];   // blocks handed out, used to pick sane frees
    int                          mismatches;

    function new();
      foreach (link_mem[i]) link_mem[i] = '0;
      mismatches = 0;
      set_pool(fbfla_pkg::CNT_W'(256));
    endfunction

    // Out-of-range counts are clamped; any write restarts the list.
    function void set_pool(logic [fbfla_pkg::CNT_W-1:0] v);
      pool_n = (v == 0) ? fbfla_pkg::CNT_W'(1) : (v > 256 ? fbfla_pkg::CNT_W'(256) : v);
      if (pool_n > fbfla_pkg::BLOCKS) pool_n = fbfla_pkg::CNT_W'(fbfla_pkg::BLOCKS);
      head_blk  = '0;
      head_live = 1'b1;
      free_n    = pool_n;
      linked_n  = '0;
      held_q.delete();
    endfunction

    function void note_request(req_kind_t k, logic [fbfla_pkg::IDX_W-1:0] idx);
      result_t r;
      r        = '0;
      r.in_rng = ({1'b0, idx} < pool_n);
      if (k == REQ_ALLOC) begin
        // lazy build: thread one more never-linked block per allocate
        if (linked_n < pool_n) begin
          link_mem[linked_n[fbfla_pkg::IDX_W-1:0]] = linked_n + 1'b1;
          linked_n++;
        end
        if (free_n != 0) begin
          r.ok      = 1'b1;
          r.granted = head_blk;
          free_n--;
          if (free_n != 0) begin
            head_blk  = link_mem[r.granted][fbfla_pkg::IDX_W-1:0];  // bad links cut to 8 bits
            head_live = 1'b1;
          end else begin
            head_blk  = '0;
            head_live = 1'b0;
          end
          held_q.push_back(r.granted);
        end
      end else if (r.in_rng && free_n < pool_n) begin
        // pushing onto an empty list stores the end marker
        link_mem[idx] = head_live ? {1'b0, head_blk} : pool_n;
        head_blk  = idx;
        head_live = 1'b1;
        free_n++;
        r.ok = 1'b1;
        for (int i = 0; i < held_q.size(); i++) begin
          if (held_q[i] == idx) begin
            held_q.delete(i);
            break;
          end
        end
      end
      r.free_n = free_n;
      outcome_q.push_back(r);
    endfunction

    task report(string what);
      if (mismatches < 30) $display("ERROR: %s", what);
      mismatches++;
    endtask

    task check_result(logic [fbfla_pkg::OUT_DATA_W-1:0] d);
      result_t got;
      result_t want;
      got = d[$bits(result_t)-1:0];
      if (outcome_q.size() == 0) begin
        report($sformatf("result %h arrived with nothing pending", d));
        return;
      end
      want = outcome_q.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok %b, want %b", got.ok, want.ok));
      if (got.granted !== want.granted)
        report($sformatf("granted_index %0d, want %0d", got.granted, want.granted));
      if (got.free_n !== want.free_n)
        report($sformatf("free_count %0d, want %0d", got.free_n, want.free_n));
      if (got.in_rng !== want.in_rng)
        report($sformatf("in_range %b, want %b", got.in_rng, want.in_rng));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [fbfla_pkg::IN_DATA_W-1:0]  in_tdata;    // [7:0] block_index
  logic                             in_tuser;    // [0] kind
  logic                             out_tvalid;
  logic                             out_tready;
  // [0] ok, [8:1] granted_index, [17:9] free_count, [18] in_range
  logic [fbfla_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             cfg_wr_en;
  logic [fbfla_pkg::CNT_W-1:0]      cfg_wr_data;

  free_list_predictor tracker;
  bit                 calm;            // when set, neither side idles
  int                 stall_left;
  int                 cycle_count;

  fixed_block_free_list_allocator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Random idle length per item. Now and then flip into (or out of)
  // a stretch with no idling at all on either side.
  function int pick_gap();
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 8));
  endfunction

  // Random block index over 0..hi.
  function logic [fbfla_pkg::IDX_W-1:0] pick_idx(int hi);
    return fbfla_pkg::IDX_W'($urandom_range(0, hi));
  endfunction

  // Result side: sample at the rising edge, change tready at the falling one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata);
      stall_left = pick_gap();
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog; sized for ~2000 items at worst-case gaps and stalls, many times over.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One request: optional idle gap, then hold tvalid until accepted.
  // tvalid stays high on return so back-to-back items need no re-raise.
  task automatic send_request(req_kind_t k, logic [fbfla_pkg::IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= idx;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(k, idx);
  endtask

  // New pool size: only once the block has drained every pending result.
  task automatic set_pool(logic [fbfla_pkg::CNT_W-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_pool(v);
  endtask

  // Mostly legal traffic: allocates, and frees of blocks actually held.
  // A slice is noise: random kind and index (double frees, out-of-range).
  task automatic run_random(int n, int alloc_pct);
    int r;
    int span;
    for (int i = 0; i < n; i++) begin
      r    = $urandom_range(0, 99);
      span = (tracker.pool_n > 255) ? 255 : int'(tracker.pool_n);
      if (r < 8) begin
        send_request(req_kind_t'($urandom_range(0, 1)), pick_idx(255));
      end else if (r < 8 + alloc_pct * 92 / 100) begin
        send_request(REQ_ALLOC, $urandom_range(0, 1) ? pick_idx(span) : pick_idx(255));
      end else if (tracker.held_q.size() > 0) begin
        send_request(REQ_FREE, tracker.held_q[$urandom_range(0, tracker.held_q.size() - 1)]);
      end else begin
        send_request(REQ_FREE, pick_idx(span));
      end
    end
  endtask

  initial begin
    int plan [];
    int pct;
    plan        = '{2, 0, 3, 511, 8, 256, 1, 17, 255, 4, 300, 64, 6, 256};
    tracker     = new();
    calm        = 1'b0;
    stall_left  = 0;
    cycle_count = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_ALLOC;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Exhaust the 256-block pool from reset (plus two failing allocates);
    // this also links every store entry, so later traffic never reads an
    // entry that was never written. Then hand every block back in random
    // order: the first free lands on an empty list.
    repeat (258) send_request(REQ_ALLOC, pick_idx(255));
    while (tracker.held_q.size() > 0)
      send_request(REQ_FREE, tracker.held_q[$urandom_range(0, tracker.held_q.size() - 1)]);
    send_request(REQ_FREE, 8'd0);     // everything already free: rejected

    // Directed corner cases.
    send_request(REQ_ALLOC, 8'd255);
    send_request(REQ_ALLOC, 8'd0);
    send_request(REQ_FREE, 8'd255);   // may hit a block not held
    send_request(REQ_FREE, 8'd255);
    set_pool(9'd1);                   // smallest pool
    send_request(REQ_ALLOC, 8'd0);
    send_request(REQ_ALLOC, 8'd1);    // no block left
    send_request(REQ_FREE, 8'd1);     // just past the pool
    send_request(REQ_FREE, 8'd255);
    send_request(REQ_FREE, 8'd0);     // onto an empty list
    send_request(REQ_FREE, 8'd0);     // all free
    send_request(REQ_ALLOC, 8'd0);
    set_pool(9'd0);                   // clamps to one block
    send_request(REQ_ALLOC, 8'd0);
    send_request(REQ_FREE, 8'd0);
    set_pool(9'd2);
    send_request(REQ_ALLOC, 8'd1);
    send_request(REQ_ALLOC, 8'd2);
    send_request(REQ_ALLOC, 8'd1);
    send_request(REQ_FREE, 8'd1);
    send_request(REQ_FREE, 8'd0);
    send_request(REQ_FREE, 8'd2);
    send_request(REQ_ALLOC, 8'd0);
    send_request(REQ_ALLOC, 8'd0);

    // Random phases over a spread of pool sizes, extremes included.
    foreach (plan[p]) begin
      set_pool(fbfla_pkg::CNT_W'(plan[p]));
      pct = ($urandom_range(0, 2) == 0) ? 30 : ($urandom_range(0, 1) ? 50 : 70);
      run_random((plan[p] > 32) ? 100 : 40, pct);
    end
    repeat (3) begin
      set_pool(fbfla_pkg::CNT_W'($urandom_range(1, 16)));
      run_random(40, 50);
    end

    // Drain, then keep watching for stray results before the verdict.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outcome_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
